// ----- rtl/dcr_pkg.sv -----
// dcr_pkg: shared widths, register indexes, fixed-point constants and helpers
// for the dual comb reverb. No dependencies; imported by every rtl/dcr_* file.
package dcr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_DELAY   = 4096;
  localparam int ADDR_W      = $clog2(MAX_DELAY);
  localparam int DLY_W       = ADDR_W + 1;
  localparam int MUL_W       = 19;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int COEF_W      = 16;
  // m + (product >>> 16) before clamping
  localparam int SAT_W       = PROD_W - 15;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_IDX_W-1:0]          cfg_idx_t;

  localparam cfg_idx_t REG_BYPASS  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ROOM    = cfg_idx_t'(1);
  localparam cfg_idx_t REG_DAMPING = cfg_idx_t'(2);
  localparam cfg_idx_t REG_WET_DRY = cfg_idx_t'(3);

  // base delays in tenths of a frame divided by 16 (14256/16, 17808/16);
  // the remaining /81920 is >>14 then /5
  localparam int BASE_A_Q  = 891;
  localparam int BASE_B_Q  = 1113;
  // floor(v/5) = (v * 52429) >> 18, exact for v < 2^18
  localparam int DIV5_MUL  = 52429;
  localparam int GAIN_CAP  = 62259;
  // (196608 + 4r)/4
  localparam int GAIN_BIAS = 49152;
  localparam int ONE_Q16   = 65536;
  localparam int TWO_Q16   = 131072;

  localparam logic [CFG_DATA_W-1:0] ROOM_RESET = CFG_DATA_W'(32768);
  localparam logic [CFG_DATA_W-1:0] DAMP_RESET = CFG_DATA_W'(32768);
  localparam logic [CFG_DATA_W-1:0] WET_RESET  = CFG_DATA_W'(19661);

  typedef struct packed {
    logic              wr_en_a;
    logic              wr_en_b;
    logic              rd_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
  } line_ctl_t;

  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(2 ** (SAMPLE_BITS - 1)));

  function automatic sample_t sat_sample(input logic signed [SAT_W-1:0] v);
    sample_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/dcr_mul.sv -----
// dcr_mul: shared signed multiplier with registered product.
// Depends on dcr_pkg (MUL_W, PROD_W).
module dcr_mul
  import dcr_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_x,
  input  logic signed [MUL_W-1:0]  op_y,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_x) * PROD_W'(op_y);
  end

endmodule

// ----- rtl/dcr_lines.sv -----
// dcr_lines: the two comb delay stores, one write port each (shared address
// and data) and one registered read port each. Depends on dcr_pkg.
module dcr_lines
  import dcr_pkg::*;
(
  input  logic      clk,
  input  line_ctl_t ctl,
  input  sample_t   wr_data,
  output sample_t   rd_data_a,
  output sample_t   rd_data_b
);

  sample_t mem_a [MAX_DELAY];
  sample_t mem_b [MAX_DELAY];

  always_ff @(posedge clk) begin
    if (ctl.wr_en_a) begin
      mem_a[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_a <= mem_a[ctl.rd_addr_a];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en_b) begin
      mem_b[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_b <= mem_b[ctl.rd_addr_b];
    end
  end

endmodule

// ----- rtl/dual_comb_reverb_top.sv -----
// dual_comb_reverb_top: two-line feedback comb reverb, sequencer, config
// registers and output register. Uses dcr_pkg, dcr_mul and dcr_lines.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------
//   in       | in_valid / in_ready  | left_sample, right_sample
//   out      | out_valid / out_ready| out_left, out_right
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A reverb beat runs the states S_DLA through S_RES, then S_OUT loads its result
// into the output register. Every multiply goes through the one 19x19 multiplier,
// one product per cycle. A bypass beat goes from S_IDLE straight to S_OUT.
// in_ready is high only while the sequencer is idle; a full output register
// holds the sequencer in S_OUT until out_ready. After rst the stores are zeroed
// one row per cycle; in_ready stays low until all 4096 are done; cfg_ready is always 1.
module dual_comb_reverb_top
  import dcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               left_sample,
  input  sample_t               right_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sample_t               out_left,
  output sample_t               out_right,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DLA, S_DLA5, S_DLB, S_DLB5, S_GN, S_GN5,
    S_FBA, S_FBB, S_WET, S_MIX, S_RES, S_OUT
  } state_t;

  state_t state;

  // config
  logic              bypass;
  logic [COEF_W-1:0] room;
  logic [COEF_W-1:0] damping;
  logic [COEF_W-1:0] wet_dry;

  // control
  logic [ADDR_W-1:0] wp;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic              out_load;   // result moves into the output register

  // per-beat working registers
  sample_t           m_reg;
  logic [DLY_W-1:0]  delay_a;
  logic [DLY_W-1:0]  delay_b;
  logic [COEF_W-1:0] g_reg;
  sample_t           res_l;
  sample_t           res_r;

  logic signed [MUL_W-1:0]  op_x;
  logic signed [MUL_W-1:0]  op_y;
  logic signed [PROD_W-1:0] prod;

  line_ctl_t line_ctl;
  sample_t   line_wr_data;
  sample_t   rd_a;
  sample_t   rd_b;

  // combinational helpers
  logic signed [SAMPLE_BITS:0]   lr_sum;
  sample_t                       m_now;
  logic [17:0]                   span_q;     // 65536 + 3r
  logic [16:0]                   gain_rs;    // 49152 + r
  logic [17:0]                   damp_inv2;  // 131072 - d
  logic [16:0]                   damp_inv;   // 65536 - d
  logic [PROD_W-19:0]            q18;        // prod >> 18
  logic [DLY_W-1:0]              dly_now;
  logic [COEF_W-1:0]             g_now;
  logic signed [SAT_W-1:0]       acc_sum;    // m + floor(prod / 65536)
  sample_t                       acc_sat;
  sample_t                       rev;
  logic signed [SAMPLE_BITS:0]   rev_m;
  logic signed [SAMPLE_BITS:0]   ab_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE) && !clearing;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  assign lr_sum    = (SAMPLE_BITS + 1)'(left_sample) + (SAMPLE_BITS + 1)'(right_sample);
  assign m_now     = lr_sum[SAMPLE_BITS:1];
  assign span_q    = 18'(ONE_Q16) + 18'(room) + {1'b0, room, 1'b0};
  assign gain_rs   = 17'(GAIN_BIAS) + 17'(room);
  assign damp_inv2 = 18'(TWO_Q16) - 18'(damping);
  assign damp_inv  = 17'(ONE_Q16) - 17'(damping);
  assign q18       = prod[PROD_W-1:18];

  // delay clamp to [1, MAX_DELAY]
  always_comb begin
    if (q18 == '0) begin
      dly_now = DLY_W'(1);
    end else if (q18 > (PROD_W - 18)'(MAX_DELAY)) begin
      dly_now = DLY_W'(MAX_DELAY);
    end else begin
      dly_now = q18[DLY_W-1:0];
    end
  end

  assign g_now   = (q18 > (PROD_W - 18)'(GAIN_CAP)) ? COEF_W'(GAIN_CAP) : q18[COEF_W-1:0];
  assign acc_sum = SAT_W'(m_reg) + SAT_W'($signed(prod[PROD_W-1:16]));
  assign acc_sat = sat_sample(acc_sum);
  assign rev     = $signed(prod[SAMPLE_BITS+16:17]);
  assign rev_m   = (SAMPLE_BITS + 1)'(rev) - (SAMPLE_BITS + 1)'(m_reg);
  assign ab_sum  = (SAMPLE_BITS + 1)'(rd_a) + (SAMPLE_BITS + 1)'(rd_b);

  // operand select for the shared multiplier
  always_comb begin
    op_x = '0;
    op_y = '0;
    unique case (state)
      S_DLA: begin
        op_x = MUL_W'(BASE_A_Q);
        op_y = MUL_W'(span_q);
      end
      S_DLB: begin
        op_x = MUL_W'(BASE_B_Q);
        op_y = MUL_W'(span_q);
      end
      S_DLA5, S_DLB5: begin
        op_x = MUL_W'(prod[31:14]);
        op_y = MUL_W'(DIV5_MUL);
      end
      S_GN: begin
        op_x = MUL_W'(gain_rs);
        op_y = MUL_W'(damp_inv2);
      end
      S_GN5: begin
        op_x = MUL_W'(prod[33:16]);
        op_y = MUL_W'(DIV5_MUL);
      end
      S_FBA: begin
        op_x = MUL_W'(rd_a);
        op_y = MUL_W'(g_now);
      end
      S_FBB: begin
        op_x = MUL_W'(rd_b);
        op_y = MUL_W'(g_reg);
      end
      S_WET: begin
        op_x = MUL_W'(ab_sum);
        op_y = MUL_W'(damp_inv);
      end
      S_MIX: begin
        op_x = MUL_W'(rev_m);
        op_y = MUL_W'(wet_dry);
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
  end

  // store port control; the zeroing sweep owns the write port after reset
  always_comb begin
    line_ctl.rd_en     = (state == S_GN5);
    line_ctl.rd_addr_a = wp - delay_a[ADDR_W-1:0];
    line_ctl.rd_addr_b = wp - delay_b[ADDR_W-1:0];
    if (clearing) begin
      line_ctl.wr_en_a = 1'b1;
      line_ctl.wr_en_b = 1'b1;
      line_ctl.wr_addr = clr_addr;
      line_wr_data     = '0;
    end else begin
      line_ctl.wr_en_a = (state == S_FBB);
      line_ctl.wr_en_b = (state == S_WET);
      line_ctl.wr_addr = wp;
      line_wr_data     = acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bypass    <= 1'b1;
      room      <= ROOM_RESET;
      damping   <= DAMP_RESET;
      wet_dry   <= WET_RESET;
      wp        <= '0;
      clearing  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BYPASS:  bypass  <= cfg_data[0];
          REG_ROOM:    room    <= cfg_data;
          REG_DAMPING: damping <= cfg_data;
          REG_WET_DRY: wet_dry <= cfg_data;
          default: ;
        endcase
      end

      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == '1) begin
          clearing <= 1'b0;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
        out_left  <= res_l;
        out_right <= res_r;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (bypass) begin
              res_l <= left_sample;
              res_r <= right_sample;
              state <= S_OUT;
            end else begin
              m_reg <= m_now;
              state <= S_DLA;
            end
          end
        end
        S_DLA:  state <= S_DLA5;
        S_DLA5: state <= S_DLB;
        S_DLB: begin
          delay_a <= dly_now;
          state   <= S_DLB5;
        end
        S_DLB5: state <= S_GN;
        S_GN: begin
          delay_b <= dly_now;
          state   <= S_GN5;
        end
        S_GN5:  state <= S_FBA;
        S_FBA: begin
          g_reg <= g_now;
          state <= S_FBB;
        end
        S_FBB:  state <= S_WET;
        S_WET:  state <= S_MIX;
        S_MIX:  state <= S_RES;
        S_RES: begin
          res_l <= acc_sat;
          res_r <= acc_sat;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (!bypass) begin
              wp <= wp + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  dcr_mul u_mul (
    .clk  (clk),
    .op_x (op_x),
    .op_y (op_y),
    .prod (prod)
  );

  dcr_lines u_lines (
    .clk       (clk),
    .ctl       (line_ctl),
    .wr_data   (line_wr_data),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

endmodule
